// ===== hdl/sssd_pkg.sv =====
// ----------------------------------------------------------------------------
// sssd_pkg
// types, register map and protocol constants shared by the dump slave modules
// ----------------------------------------------------------------------------
package sssd_pkg;

  // apb register map
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_START_MARKER = 3'd0;
  localparam logic [2:0] REG_END_MARKER   = 3'd1;
  localparam logic [2:0] REG_ERROR_CODE   = 3'd2;
  localparam logic [2:0] REG_READY_CODE   = 3'd3;
  localparam logic [2:0] REG_BUSY_CODE    = 3'd4;
  localparam logic [2:0] REG_OK_CODE      = 3'd5;

  // protocol modes
  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_WORK = 2'd1;
  localparam logic [1:0] MODE_ERR  = 2'd2;

  // counters and pad bytes
  localparam logic [4:0] WAIT_LOAD   = 5'd31;
  localparam logic [3:0] PAD_MAX     = 4'd15;
  localparam logic [3:0] PAD_ZERO_AT = 4'd2;
  localparam logic [3:0] PAD_LIMIT   = 4'd10;
  localparam logic [7:0] PAD_BYTE    = 8'hFF;
  localparam logic [7:0] ZERO_BYTE   = 8'h00;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_ready;
    logic       has_next;
    logic [7:0] next_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last_of_step;
    logic [1:0] mode;
    logic       green_lamp;
    logic       red_lamp;
    logic       pause_sampling;
    logic       resume_sampling;
    logic       consume_buffer;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start_marker;
    logic [31:0] end_marker;
    logic [7:0]  error_code;
    logic [7:0]  ready_code;
    logic [7:0]  busy_code;
    logic [7:0]  ok_code;
  } cfg_t;

  typedef struct packed {
    logic [31:0] hist;
    logic [1:0]  mode;
    logic [4:0]  start_timeout;
    logic [4:0]  busy_retries;
    logic [3:0]  pad;
    logic        seen;
    logic        green;
    logic        red;
  } proto_state_t;

  // everything one received byte produces
  typedef struct packed {
    logic            tx_any;
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic [1:0]      mode;
    logic            green;
    logic            red;
    logic            pause;
    logic            resume;
    logic            consume;
  } step_res_t;

endpackage

// ===== hdl/sssd_regs.sv =====
// ----------------------------------------------------------------------------
// sssd_regs
// apb register file holding the markers and reply codes
// ----------------------------------------------------------------------------
module sssd_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sssd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output sssd_pkg::cfg_t             cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[sssd_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        sssd_pkg::REG_START_MARKER: cfg.start_marker <= pwdata;
        sssd_pkg::REG_END_MARKER:   cfg.end_marker   <= pwdata;
        sssd_pkg::REG_ERROR_CODE:   cfg.error_code   <= pwdata[7:0];
        sssd_pkg::REG_READY_CODE:   cfg.ready_code   <= pwdata[7:0];
        sssd_pkg::REG_BUSY_CODE:    cfg.busy_code    <= pwdata[7:0];
        sssd_pkg::REG_OK_CODE:      cfg.ok_code      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sssd_pkg::REG_START_MARKER: prdata = cfg.start_marker;
      sssd_pkg::REG_END_MARKER:   prdata = cfg.end_marker;
      sssd_pkg::REG_ERROR_CODE:   prdata = {24'd0, cfg.error_code};
      sssd_pkg::REG_READY_CODE:   prdata = {24'd0, cfg.ready_code};
      sssd_pkg::REG_BUSY_CODE:    prdata = {24'd0, cfg.busy_code};
      sssd_pkg::REG_OK_CODE:      prdata = {24'd0, cfg.ok_code};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/sssd_step.sv =====
// ----------------------------------------------------------------------------
// sssd_step
// protocol state and the per-byte wait / work / error handler chain
// ----------------------------------------------------------------------------
module sssd_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                commit,
  input  sssd_pkg::in_item_t  item,
  input  sssd_pkg::cfg_t      cfg,
  output sssd_pkg::step_res_t res
);

  sssd_pkg::proto_state_t st;
  sssd_pkg::proto_state_t st_next;
  logic [31:0]     hist;
  logic            start_hit;
  logic            end_hit;
  logic [1:0]      e_cnt;
  logic [2:0][7:0] bl;
  logic            pause;
  logic            resume;
  logic            consume;

  always_comb begin
    hist      = {st.hist[23:0], item.rx_byte};
    start_hit = (hist == cfg.start_marker);
    end_hit   = (hist == cfg.end_marker);
    st_next   = st;
    st_next.hist = hist;
    pause     = 1'b0;
    resume    = 1'b0;
    consume   = 1'b0;
    e_cnt     = 2'd0;
    bl        = '0;

    // error byte from the master forces error mode first
    if (hist[7:0] == cfg.error_code) begin
      st_next.mode = sssd_pkg::MODE_ERR;
    end

    // waiting handler
    if (st_next.mode == sssd_pkg::MODE_WAIT) begin
      if (!start_hit) begin
        if (st.start_timeout == 5'd0) begin
          st_next.start_timeout = sssd_pkg::WAIT_LOAD;
          st_next.mode          = sssd_pkg::MODE_ERR;
        end else begin
          st_next.start_timeout = st.start_timeout - 5'd1;
        end
      end else begin
        st_next.start_timeout = sssd_pkg::WAIT_LOAD;
        st_next.seen          = item.buffer_ready;
        if (item.buffer_ready) begin
          pause          = 1'b1;
          st_next.mode   = sssd_pkg::MODE_WORK;
          st_next.green  = 1'b1;
          bl[e_cnt]      = cfg.ready_code;
          e_cnt          = e_cnt + 2'd1;
        end else if (st.busy_retries == 5'd0) begin
          st_next.busy_retries = sssd_pkg::WAIT_LOAD;
          st_next.mode         = sssd_pkg::MODE_ERR;
        end else begin
          st_next.busy_retries = st.busy_retries - 5'd1;
          bl[e_cnt]            = cfg.busy_code;
          e_cnt                = e_cnt + 2'd1;
        end
      end
    end

    // working handler
    if (st_next.mode == sssd_pkg::MODE_WORK) begin
      if (end_hit) begin
        st_next.pad   = 4'd0;
        st_next.mode  = sssd_pkg::MODE_WAIT;
        st_next.green = 1'b0;
        consume       = 1'b1;
        resume        = 1'b1;
      end else begin
        if (item.has_next) begin
          bl[e_cnt] = item.next_byte;
          consume   = 1'b1;
        end else begin
          bl[e_cnt] = (st.pad == sssd_pkg::PAD_ZERO_AT) ? sssd_pkg::ZERO_BYTE
                                                       : sssd_pkg::PAD_BYTE;
          if (st.pad != sssd_pkg::PAD_MAX) begin
            st_next.pad = st.pad + 4'd1;
          end
        end
        e_cnt = e_cnt + 2'd1;
        if (st_next.pad >= sssd_pkg::PAD_LIMIT) begin
          st_next.mode = sssd_pkg::MODE_ERR;
        end
      end
    end

    // error handler
    if (st_next.mode == sssd_pkg::MODE_ERR) begin
      st_next.red = 1'b0;
      if (end_hit) begin
        st_next.mode = sssd_pkg::MODE_WAIT;
        st_next.red  = 1'b1;
        bl[e_cnt]    = cfg.ok_code;
        consume      = consume | st_next.seen;
        resume       = 1'b1;
      end else begin
        bl[e_cnt]    = cfg.error_code;
      end
      e_cnt = e_cnt + 2'd1;
    end

    res.tx_any  = (e_cnt != 2'd0);
    res.cnt     = (e_cnt == 2'd0) ? 2'd1 : e_cnt;
    res.bytes   = bl;
    res.mode    = st_next.mode;
    res.green   = st_next.green;
    res.red     = st_next.red;
    res.pause   = pause;
    res.resume  = resume;
    res.consume = consume;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.hist          <= 32'd0;
      st.mode          <= sssd_pkg::MODE_WAIT;
      st.start_timeout <= sssd_pkg::WAIT_LOAD;
      st.busy_retries  <= sssd_pkg::WAIT_LOAD;
      st.pad           <= 4'd0;
      st.seen          <= 1'b0;
      st.green         <= 1'b0;
      st.red           <= 1'b1;
    end else if (commit) begin
      st <= st_next;
    end
  end

  // the end marker always leaves the protocol waiting
  a_end_to_wait: assert property (@(posedge clk) disable iff (rst)
    commit && end_hit &&
    (st.mode == sssd_pkg::MODE_WAIT || st.mode == sssd_pkg::MODE_WORK ||
     st.mode == sssd_pkg::MODE_ERR)
    |=> st.mode == sssd_pkg::MODE_WAIT)
    else $error("end marker did not return to waiting");

  // a step that ends in error mode ran the error handler, red lamp is off
  a_err_red_off: assert property (@(posedge clk) disable iff (rst)
    commit && res.mode == sssd_pkg::MODE_ERR |-> !res.red)
    else $error("red lamp lit in error mode");

endmodule

// ===== hdl/sssd_drain.sv =====
// ----------------------------------------------------------------------------
// sssd_drain
// step result slot and output register, one transmit word per cycle while out_ready is high
// ----------------------------------------------------------------------------
module sssd_drain (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  sssd_pkg::step_res_t res,
  output logic                slot_free,
  output logic                out_valid,
  input  logic                out_ready,
  output sssd_pkg::out_item_t out_data
);

  logic                slot_valid;
  sssd_pkg::step_res_t slot;
  logic [1:0]          slot_idx;
  logic                slot_last;
  logic                out_load;
  logic [7:0]          word_byte;

  assign out_load  = slot_valid & (~out_valid | out_ready);
  assign slot_last = ((slot_idx + 2'd1) == slot.cnt);
  assign slot_free = ~slot_valid | (out_load & slot_last);

  always_comb begin
    case (slot_idx)
      2'd0:    word_byte = slot.bytes[0];
      2'd1:    word_byte = slot.bytes[1];
      2'd2:    word_byte = slot.bytes[2];
      default: word_byte = sssd_pkg::ZERO_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      slot_idx   <= 2'd0;
    end else if (load) begin
      slot_valid <= 1'b1;
      slot_idx   <= 2'd0;
    end else if (out_load) begin
      if (slot_last) begin
        slot_valid <= 1'b0;
      end else begin
        slot_idx <= slot_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.tx_valid        <= slot.tx_any;
      out_data.tx_byte         <= word_byte;
      out_data.last_of_step    <= slot_last;
      out_data.mode            <= slot.mode;
      out_data.green_lamp      <= slot.green;
      out_data.red_lamp        <= slot.red;
      out_data.pause_sampling  <= slot.pause;
      out_data.resume_sampling <= slot.resume;
      out_data.consume_buffer  <= slot.consume;
    end
  end

  // the read position never passes the number of words in the slot
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    slot_valid |-> slot_idx < slot.cnt)
    else $error("slot index past word count");

  // a silent step gives exactly one word, which closes the step
  a_silent_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.tx_valid |-> out_data.last_of_step)
    else $error("silent word not marked last");

endmodule

// ===== hdl/spi_slave_sample_dump_protocol.sv =====
// ----------------------------------------------------------------------------
// spi_slave_sample_dump_protocol
// slave side of the sample dump exchange: one received byte in, its replies out
// ----------------------------------------------------------------------------
// Each accepted word is one byte received from the spi master together with
// the sample buffer status. The byte is shifted into a 32-bit history and the
// waiting, working and error handlers run on it in that order, so one byte can
// pass through several of them and yield up to three transmit words. A byte
// that writes nothing still yields one word with tx_valid low that carries the
// lamp levels and the sampling / consume pulses. Every word of a byte carries
// the same mode, lamps and pulses; last_of_step marks the final one. Data path:
// an input register, the handler logic, a result slot and an output register,
// in that order. The output register sends one word per cycle while out_ready
// is high, so a byte holds it until all its words are sent, and the input side
// keeps accepting a byte every cycle as long as each byte yields one word and
// the output keeps up. Markers and reply codes sit in apb registers at byte
// addresses 0x00 (start marker), 0x04 (end marker), 0x08 (error code), 0x0c
// (ready code), 0x10 (busy code), 0x14 (ok code); all reset to zero. The user
// writes them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module spi_slave_sample_dump_protocol (
  input  logic                        clk,
  input  logic                        rst,
  // received byte channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sssd_pkg::in_item_t          in_data,
  // transmit word channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output sssd_pkg::out_item_t         out_data,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sssd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  sssd_pkg::cfg_t      cfg;
  sssd_pkg::in_item_t  in_r;
  logic                in_valid_r;
  sssd_pkg::step_res_t res;
  logic                slot_free;
  logic                commit;

  // a held byte moves into the result slot once the slot is empty or drains its last word
  assign commit   = in_valid_r & slot_free;
  // input register refills in the same cycle it hands its byte on
  assign in_ready = ~in_valid_r | commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (commit) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // marker and reply code registers
  sssd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handler chain and protocol state, advanced on commit
  sssd_step u_step (
    .clk    (clk),
    .rst    (rst),
    .commit (commit),
    .item   (in_r),
    .cfg    (cfg),
    .res    (res)
  );

  // result slot unrolled into transmit words
  sssd_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .load      (commit),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
